>>> hdl/wavetable_frame_morph_lookup_macros.svh
// assertion macros for the wavetable frame morph lookup
`ifndef WAVETABLE_FRAME_MORPH_LOOKUP_MACROS_SVH
`define WAVETABLE_FRAME_MORPH_LOOKUP_MACROS_SVH

// consequent checked in the same cycle
`define WFML_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define WFML_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/wfml_pkg.sv
// shared types and constants of the wavetable frame morph lookup
package wfml_pkg;

    localparam int unsigned FRAME_SAMPLES = 2048;
    localparam int unsigned FRAME_SPAN    = 15;

    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned ADDR_IN_W = 12;
    localparam int unsigned PF_W      = 24;
    localparam int unsigned MORPH_W   = 16;
    localparam int unsigned FF_W      = 16;
    localparam int unsigned BASE_W    = 4;

    localparam int unsigned OUTQ_DEPTH = 4;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic [1:0] {
        STEP_A0,
        STEP_B0,
        STEP_A1,
        STEP_B1
    } t_step;

    typedef enum logic [1:0] {
        SEL_LOWER,
        SEL_UPPER,
        SEL_BLEND
    } t_sel;

    typedef struct packed {
        logic            vld;
        t_step           step;
        logic [PF_W-1:0] pf;
        t_sel            sel;
        logic [FF_W-1:0] ff;
    } t_tag;

endpackage

>>> hdl/wfml_store.sv
// single-port sample store with registered read data
module wfml_store #(
    parameter int unsigned DEPTH = 2 * wfml_pkg::FRAME_SAMPLES,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_addr,
    input  wfml_pkg::t_sample i_wdata,
    output wfml_pkg::t_sample o_rdata
);

    wfml_pkg::t_sample r_mem [DEPTH];
    wfml_pkg::t_sample r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/wfml_seq.sv
// input stage and store access sequencer, four reads per read word
module wfml_seq #(
    parameter int unsigned FRAME_SAMPLES = wfml_pkg::FRAME_SAMPLES,
    parameter int unsigned FRAME_SPAN    = wfml_pkg::FRAME_SPAN,
    localparam int unsigned AW = $clog2(2 * FRAME_SAMPLES)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_mode,
    input  logic [wfml_pkg::ADDR_IN_W-1:0] i_write_address,
    input  wfml_pkg::t_sample              i_write_data,
    input  logic [wfml_pkg::PF_W-1:0]      i_phase,
    input  logic [wfml_pkg::MORPH_W-1:0]   i_morph,
    input  logic [wfml_pkg::BASE_W-1:0]    i_base_frame,
    input  logic                           i_pop,
    output logic                           o_mem_we,
    output logic [AW-1:0]                  o_mem_addr,
    output wfml_pkg::t_sample              o_mem_wdata,
    output wfml_pkg::t_tag                 o_tag
);

    localparam int unsigned IW    = $clog2(FRAME_SAMPLES);
    localparam int unsigned PW    = wfml_pkg::PF_W + IW;
    localparam int unsigned SW    = $clog2(FRAME_SPAN + 1);
    localparam int unsigned MW    = wfml_pkg::FF_W + SW;
    localparam int unsigned CW    = $clog2(wfml_pkg::OUTQ_DEPTH + 1);
    localparam int unsigned DEPTH = 2 * FRAME_SAMPLES;

    logic                           r_busy;
    wfml_pkg::t_step                r_step;
    logic [CW-1:0]                  r_cnt;
    logic                           n_busy;
    wfml_pkg::t_step                n_step;
    logic [CW-1:0]                  n_cnt;

    logic                           r_mode;
    logic [wfml_pkg::ADDR_IN_W-1:0] r_waddr;
    wfml_pkg::t_sample              r_wdata;
    logic [IW-1:0]                  r_idx;
    logic [IW-1:0]                  r_nxt;
    logic [wfml_pkg::PF_W-1:0]      r_pf;
    wfml_pkg::t_sel                 r_sel;
    logic [wfml_pkg::FF_W-1:0]      r_ff;

    logic [PW-1:0]                  w_prod;
    logic [IW-1:0]                  w_idx;
    logic [IW-1:0]                  w_nxt;
    logic [wfml_pkg::PF_W-1:0]      w_pf;
    logic [MW-1:0]                  w_m;
    logic [SW-1:0]                  w_fi;
    logic [wfml_pkg::FF_W-1:0]      w_ff;
    wfml_pkg::t_sel                 w_sel;
    logic                           w_last;
    logic                           w_free;
    logic                           w_credit;
    logic                           w_accept;
    logic                           w_in_range;

    // phase and morph split at the input
    always_comb begin
        w_prod = PW'(i_phase) * PW'(FRAME_SAMPLES);
        w_idx  = w_prod[PW-1:wfml_pkg::PF_W];
        w_pf   = w_prod[wfml_pkg::PF_W-1:0];
        w_nxt  = (w_idx == IW'(FRAME_SAMPLES - 1)) ? '0 : w_idx + IW'(1);
        w_m    = MW'(i_morph) * MW'(FRAME_SPAN);
        w_fi   = w_m[MW-1:wfml_pkg::FF_W];
        w_ff   = w_m[wfml_pkg::FF_W-1:0];
        priority if (32'(w_fi) > 32'(i_base_frame)) begin
            w_sel = wfml_pkg::SEL_UPPER;
        end else if (32'(w_fi) < 32'(i_base_frame)) begin
            w_sel = wfml_pkg::SEL_LOWER;
        end else begin
            w_sel = wfml_pkg::SEL_BLEND;
        end
    end

    assign w_last   = r_busy && (!r_mode || (r_step == wfml_pkg::STEP_B1));
    assign w_free   = !r_busy || w_last;
    assign w_credit = r_cnt < CW'(wfml_pkg::OUTQ_DEPTH);
    assign o_ready  = i_rst_n && w_free && (!i_mode || w_credit);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (w_accept) begin
            n_busy = 1'b1;
            n_step = wfml_pkg::STEP_A0;
        end else if (w_last) begin
            n_busy = 1'b0;
        end else if (r_busy) begin
            unique case (r_step)
                wfml_pkg::STEP_A0: n_step = wfml_pkg::STEP_B0;
                wfml_pkg::STEP_B0: n_step = wfml_pkg::STEP_A1;
                wfml_pkg::STEP_A1: n_step = wfml_pkg::STEP_B1;
                wfml_pkg::STEP_B1: n_step = wfml_pkg::STEP_A0;
            endcase
        end
        // one credit per read word until its result leaves the output queue
        n_cnt = r_cnt + CW'(w_accept && i_mode) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= wfml_pkg::STEP_A0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= i_mode;
            r_waddr <= i_write_address;
            r_wdata <= i_write_data;
            r_idx   <= w_idx;
            r_nxt   <= w_nxt;
            r_pf    <= w_pf;
            r_sel   <= w_sel;
            r_ff    <= w_ff;
        end
    end

    assign w_in_range  = 32'(r_waddr) < DEPTH;
    assign o_mem_we    = r_busy && !r_mode && w_in_range;
    assign o_mem_wdata = r_wdata;

    always_comb begin
        o_mem_addr = AW'(r_waddr);
        if (r_mode) begin
            unique case (r_step)
                wfml_pkg::STEP_A0: o_mem_addr = AW'(r_idx);
                wfml_pkg::STEP_B0: o_mem_addr = AW'(r_nxt);
                wfml_pkg::STEP_A1: o_mem_addr = AW'(FRAME_SAMPLES) + AW'(r_idx);
                wfml_pkg::STEP_B1: o_mem_addr = AW'(FRAME_SAMPLES) + AW'(r_nxt);
            endcase
        end
    end

    always_comb begin
        o_tag.vld  = r_busy && r_mode;
        o_tag.step = r_step;
        o_tag.pf   = r_pf;
        o_tag.sel  = r_sel;
        o_tag.ff   = r_ff;
    end

endmodule

>>> hdl/wfml_interp.sv
// interpolation and crossfade datapath behind the store read port
module wfml_interp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wfml_pkg::t_sample i_rdata,
    input  wfml_pkg::t_tag    i_tag,
    output logic              o_push,
    output wfml_pkg::t_sample o_sample
);

    localparam int unsigned DW     = wfml_pkg::SAMPLE_W + 1;
    localparam int unsigned PROD_W = DW + wfml_pkg::PF_W + 1;
    localparam int unsigned Q_W    = DW + wfml_pkg::FF_W + 1;
    localparam int unsigned QI_W   = PROD_W - wfml_pkg::PF_W + 1;
    localparam int unsigned QB_W   = Q_W - wfml_pkg::FF_W + 1;

    function automatic wfml_pkg::t_sample f_interp(
        input wfml_pkg::t_sample         a,
        input logic signed [PROD_W-1:0]  p
    );
        logic signed [PROD_W:0] num;
        logic [QI_W-1:0] q;
        num = $signed({{3{a[wfml_pkg::SAMPLE_W-1]}}, a, {wfml_pkg::PF_W{1'b0}}})
            + (PROD_W + 1)'(p);
        q = num[PROD_W:wfml_pkg::PF_W];
        // toward zero
        if (num[PROD_W] && (|num[wfml_pkg::PF_W-1:0])) begin
            q = q + QI_W'(1);
        end
        return q[wfml_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic wfml_pkg::t_sample f_blend(
        input wfml_pkg::t_sample      s0,
        input logic signed [Q_W-1:0]  q
    );
        logic signed [Q_W:0] num;
        logic [QB_W-1:0] r;
        num = $signed({{3{s0[wfml_pkg::SAMPLE_W-1]}}, s0, {wfml_pkg::FF_W{1'b0}}})
            + (Q_W + 1)'(q);
        r = num[Q_W:wfml_pkg::FF_W];
        if (num[Q_W] && (|num[wfml_pkg::FF_W-1:0])) begin
            r = r + QB_W'(1);
        end
        return r[wfml_pkg::SAMPLE_W-1:0];
    endfunction

    wfml_pkg::t_tag              r_tag;
    logic                        r_v1;
    logic                        r_v2;
    logic                        r_v3;

    wfml_pkg::t_sample           r_a0;
    wfml_pkg::t_sample           r_a1;
    logic signed [PROD_W-1:0]    r_p;
    wfml_pkg::t_sample           r_s0;
    wfml_pkg::t_sel              r_f1_sel;
    logic [wfml_pkg::FF_W-1:0]   r_f1_ff;
    wfml_pkg::t_sample           r_s1;
    wfml_pkg::t_sample           r_f2_s0;
    wfml_pkg::t_sel              r_f2_sel;
    logic [wfml_pkg::FF_W-1:0]   r_f2_ff;
    logic signed [Q_W-1:0]       r_q;
    wfml_pkg::t_sample           r_f3_s0;
    wfml_pkg::t_sample           r_f3_s1;
    wfml_pkg::t_sel              r_f3_sel;

    wfml_pkg::t_sample           w_a;
    logic signed [DW-1:0]        w_diff;
    logic signed [wfml_pkg::PF_W:0] w_pfs;
    logic signed [PROD_W-1:0]    w_prod;
    logic signed [DW-1:0]        w_bdiff;
    logic signed [wfml_pkg::FF_W:0] w_ffs;

    // one shared multiplier for both frames
    always_comb begin
        w_a    = (r_tag.step == wfml_pkg::STEP_B1) ? r_a1 : r_a0;
        w_diff = DW'(i_rdata) - DW'(w_a);
        w_pfs  = {1'b0, r_tag.pf};
        w_prod = w_diff * w_pfs;
    end

    always_comb begin
        w_bdiff = DW'(r_s1) - DW'(r_f2_s0);
        w_ffs   = {1'b0, r_f2_ff};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
        end else begin
            r_tag <= i_tag;
            r_v1  <= r_tag.vld && (r_tag.step == wfml_pkg::STEP_B1);
            r_v2  <= r_v1;
            r_v3  <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_tag.vld) begin
            unique case (r_tag.step)
                wfml_pkg::STEP_A0: r_a0 <= i_rdata;
                wfml_pkg::STEP_B0: r_p <= w_prod;
                wfml_pkg::STEP_A1: begin
                    r_a1 <= i_rdata;
                    r_s0 <= f_interp(r_a0, r_p);
                end
                wfml_pkg::STEP_B1: begin
                    r_p      <= w_prod;
                    r_f1_sel <= r_tag.sel;
                    r_f1_ff  <= r_tag.ff;
                end
            endcase
        end
        if (r_v1) begin
            r_s1     <= f_interp(r_a1, r_p);
            r_f2_s0  <= r_s0;
            r_f2_sel <= r_f1_sel;
            r_f2_ff  <= r_f1_ff;
        end
        if (r_v2) begin
            r_q      <= w_bdiff * w_ffs;
            r_f3_s0  <= r_f2_s0;
            r_f3_s1  <= r_s1;
            r_f3_sel <= r_f2_sel;
        end
    end

    assign o_push = r_v3;

    always_comb begin
        unique case (r_f3_sel)
            wfml_pkg::SEL_LOWER: o_sample = r_f3_s0;
            wfml_pkg::SEL_UPPER: o_sample = r_f3_s1;
            wfml_pkg::SEL_BLEND: o_sample = f_blend(r_f3_s0, r_q);
            default:             o_sample = r_f3_s0;
        endcase
    end

endmodule

>>> hdl/wfml_outq.sv
// output queue holding finished words until the receiver takes them
module wfml_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wfml_pkg::t_sample i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output wfml_pkg::t_sample o_data
);

    localparam int unsigned PTRW = $clog2(wfml_pkg::OUTQ_DEPTH);
    localparam int unsigned CW   = $clog2(wfml_pkg::OUTQ_DEPTH + 1);

    wfml_pkg::t_sample r_mem [wfml_pkg::OUTQ_DEPTH];
    logic [PTRW-1:0]   r_wp;
    logic [PTRW-1:0]   r_rp;
    logic [CW-1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PTRW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PTRW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

endmodule

>>> hdl/wavetable_frame_morph_lookup.sv
// top level of the wavetable frame morph lookup
//
// input channel: i_valid / o_ready carry one word; i_mode low writes i_write_data
// into store entry i_write_address, i_mode high reads one sample at i_phase and
// i_morph. output channel: o_valid / i_ready carry o_sample, one per read word.
// base_frame is written through i_cfg_we / i_cfg_wdata; the user must do so only
// while the block is idle; the block does not enforce it. a write word holds the
// single store port for one write, a read word for four reads (two adjacent
// samples from each frame half); reads follow back to back. o_valid rises once the
// result is written into the four-entry output queue, where finished words wait;
// while the receiver stalls, up to four read words may be outstanding, then
// o_ready drops for read words while write words are still taken.
// reset clears base_frame, the sequencer and the output queue; the store is not
// cleared and an entry must be written before it is read.
`include "wavetable_frame_morph_lookup_macros.svh"

module wavetable_frame_morph_lookup #(
    parameter int unsigned FRAME_SAMPLES = wfml_pkg::FRAME_SAMPLES,
    parameter int unsigned FRAME_SPAN    = wfml_pkg::FRAME_SPAN
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_mode,
    input  logic [wfml_pkg::ADDR_IN_W-1:0] i_write_address,
    input  logic signed [wfml_pkg::SAMPLE_W-1:0] i_write_data,
    input  logic [wfml_pkg::PF_W-1:0]      i_phase,
    input  logic [wfml_pkg::MORPH_W-1:0]   i_morph,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [wfml_pkg::SAMPLE_W-1:0] o_sample,
    input  logic                           i_cfg_we,
    input  logic [wfml_pkg::BASE_W-1:0]    i_cfg_wdata
);

    localparam int unsigned AW = $clog2(2 * FRAME_SAMPLES);

    logic [wfml_pkg::BASE_W-1:0] r_base_frame;

    logic              w_mem_we;
    logic [AW-1:0]     w_mem_addr;
    wfml_pkg::t_sample w_mem_wdata;
    wfml_pkg::t_sample w_mem_rdata;
    wfml_pkg::t_tag    w_tag;
    logic              w_push;
    wfml_pkg::t_sample w_push_data;
    logic              w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_frame <= '0;
        end else if (i_cfg_we) begin
            r_base_frame <= i_cfg_wdata;
        end
    end

    assign w_pop = o_valid && i_ready;

    wfml_seq #(
        .FRAME_SAMPLES (FRAME_SAMPLES),
        .FRAME_SPAN    (FRAME_SPAN)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_write_address (i_write_address),
        .i_write_data    (i_write_data),
        .i_phase         (i_phase),
        .i_morph         (i_morph),
        .i_base_frame    (r_base_frame),
        .i_pop           (w_pop),
        .o_mem_we        (w_mem_we),
        .o_mem_addr      (w_mem_addr),
        .o_mem_wdata     (w_mem_wdata),
        .o_tag           (w_tag)
    );

    wfml_store #(
        .DEPTH (2 * FRAME_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    wfml_interp u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rdata  (w_mem_rdata),
        .i_tag    (w_tag),
        .o_push   (w_push),
        .o_sample (w_push_data)
    );

    wfml_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_valid (o_valid),
        .o_data  (o_sample)
    );

    `WFML_ASSERT_SAME(a_write_no_read, i_clk, i_rst_n, w_mem_we, !w_tag.vld, "store write during read slot")
    `WFML_ASSERT_SAME(a_write_follows_accept, i_clk, i_rst_n, w_mem_we, $past(i_valid && o_ready && !i_mode), "store write without write word")
    `WFML_ASSERT_SAME(a_push_after_last_read, i_clk, i_rst_n, w_push, $past(w_tag.vld && (w_tag.step == wfml_pkg::STEP_B1), 4), "result pushed without its last read")

endmodule

>>> test/tb_top.sv
// testbench for the wavetable frame morph lookup: store writes and interpolated reads
module tb_top;
    import wfml_pkg::*;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    localparam int unsigned STORE_DEPTH     = 2 * FRAME_SAMPLES;
    localparam int unsigned IDX_W           = $clog2(FRAME_SAMPLES);
    localparam int unsigned FRAC_W          = PF_W - IDX_W;
    localparam longint      PHASE_ONE       = longint'(1) << PF_W;
    localparam longint      MORPH_ONE       = longint'(1) << MORPH_W;
    localparam int unsigned SETTLE_CYCLES   = 16;
    localparam int unsigned END_CYCLES      = 24;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned ITEMS_PER_PHASE = 80;

    typedef enum logic [1:0] {
        SEQ_WORD,
        SEQ_BASE,
        SEQ_PACE
    } t_seq_kind;

    typedef struct {
        t_seq_kind            kind;
        logic                 mode;
        logic [ADDR_IN_W-1:0] addr;
        t_sample              data;
        logic [PF_W-1:0]      phase;
        logic [MORPH_W-1:0]   morph;
        logic [BASE_W-1:0]    base;
        int unsigned          send_pct;
        int unsigned          recv_pct;
    } t_seq_entry;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_valid         = 1'b0;
    logic                 o_ready;
    logic                 i_mode          = MODE_WRITE;
    logic [ADDR_IN_W-1:0] i_write_address = '0;
    t_sample              i_write_data    = '0;
    logic [PF_W-1:0]      i_phase         = '0;
    logic [MORPH_W-1:0]   i_morph         = '0;
    logic                 o_valid;
    logic                 i_ready         = 1'b0;
    t_sample              o_sample;
    logic                 i_cfg_we        = 1'b0;
    logic [BASE_W-1:0]    i_cfg_wdata     = '0;

    t_seq_entry        word_queue[$];
    t_sample           pending_samples[$];
    t_sample           shadow_wave [STORE_DEPTH];
    logic [BASE_W-1:0] shadow_base = '0;
    bit                filled [STORE_DEPTH];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned settle_count  = 0;
    int unsigned stall_cycles  = 0;
    int unsigned reads_issued  = 0;
    int unsigned samples_seen  = 0;
    int unsigned writes_planned = 0;
    int unsigned reads_planned  = 0;
    int unsigned mismatch_count = 0;

    wavetable_frame_morph_lookup dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_write_address (i_write_address),
        .i_write_data    (i_write_data),
        .i_phase         (i_phase),
        .i_morph         (i_morph),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sample        (o_sample),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic longint lerp(longint a, longint b, longint frac);
        return (a * PHASE_ONE + (b - a) * frac) / PHASE_ONE;
    endfunction

    function automatic t_sample morph_lookup_sample(logic [PF_W-1:0] phase,
                                                    logic [MORPH_W-1:0] morph);
        longint p;
        longint idx;
        longint nxt;
        longint pf;
        longint m;
        longint fi;
        longint ff;
        longint s0;
        longint s1;
        longint res;
        p   = longint'(phase) * FRAME_SAMPLES;
        idx = p >> PF_W;
        pf  = p % PHASE_ONE;
        nxt = (idx + 1 == FRAME_SAMPLES) ? 0 : idx + 1;
        s0  = lerp(shadow_wave[idx], shadow_wave[nxt], pf);
        s1  = lerp(shadow_wave[FRAME_SAMPLES + idx], shadow_wave[FRAME_SAMPLES + nxt], pf);
        m   = longint'(morph) * FRAME_SPAN;
        fi  = m >> MORPH_W;
        ff  = m % MORPH_ONE;
        if (fi > longint'(shadow_base)) begin
            res = s1;
        end else if (fi < longint'(shadow_base)) begin
            res = s0;
        end else begin
            res = (s0 * (MORPH_ONE - ff) + s1 * ff) / MORPH_ONE;
        end
        return t_sample'(res);
    endfunction

    task automatic push_entry(t_seq_kind kind, logic mode, logic [ADDR_IN_W-1:0] addr,
                              t_sample data, logic [PF_W-1:0] phase,
                              logic [MORPH_W-1:0] morph, logic [BASE_W-1:0] base,
                              int unsigned send_pct, int unsigned recv_pct);
        t_seq_entry e;
        e.kind     = kind;
        e.mode     = mode;
        e.addr     = addr;
        e.data     = data;
        e.phase    = phase;
        e.morph    = morph;
        e.base     = base;
        e.send_pct = send_pct;
        e.recv_pct = recv_pct;
        word_queue.push_back(e);
    endtask

    task automatic push_pace(int unsigned send_pct, int unsigned recv_pct);
        push_entry(SEQ_PACE, MODE_WRITE, '0, '0, '0, '0, '0, send_pct, recv_pct);
    endtask

    task automatic push_base(logic [BASE_W-1:0] base);
        push_entry(SEQ_BASE, MODE_WRITE, '0, '0, '0, '0, base, 0, 0);
    endtask

    task automatic push_write(int unsigned addr, t_sample data);
        push_entry(SEQ_WORD, MODE_WRITE, addr, data, $urandom, $urandom, '0, 0, 0);
        filled[addr] = 1'b1;
        writes_planned++;
    endtask

    function automatic t_sample random_sample();
        case ($urandom_range(9))
            0:       return t_sample'(16'h8000);
            1:       return t_sample'(16'h7fff);
            2:       return t_sample'(16'h0000);
            3:       return t_sample'(16'hffff);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic logic [PF_W-1:0] random_phase();
        logic [PF_W-1:0] ph;
        ph = $urandom;
        case ($urandom_range(9))
            0:       ph[PF_W-1 -: IDX_W] = '1;
            1:       ph[PF_W-1 -: IDX_W] = '0;
            2:       ph[FRAC_W-1:0] = '0;
            3:       ph[FRAC_W-1:0] = '1;
            default: ;
        endcase
        return ph;
    endfunction

    // biased toward the crossfade band of the current base frame
    function automatic logic [MORPH_W-1:0] random_morph(logic [BASE_W-1:0] base);
        int unsigned r;
        int unsigned lo;
        int unsigned hi;
        r = $urandom_range(9);
        if (r < 4 && base < FRAME_SPAN) begin
            lo = (base * MORPH_ONE + FRAME_SPAN - 1) / FRAME_SPAN;
            hi = ((base + 1) * MORPH_ONE - 1) / FRAME_SPAN;
            if (hi > MORPH_ONE - 1) begin
                hi = MORPH_ONE - 1;
            end
            return $urandom_range(hi, lo);
        end
        if (r == 4) begin
            return $urandom_range(MORPH_ONE - 1, 65530);
        end
        return $urandom_range(MORPH_ONE - 1);
    endfunction

    // fills any of the four touched entries that were never written, then reads
    task automatic push_read(logic [PF_W-1:0] phase, logic [MORPH_W-1:0] morph);
        int unsigned idx;
        int unsigned nxt;
        int unsigned spots[4];
        idx = (longint'(phase) * FRAME_SAMPLES) >> PF_W;
        nxt = (idx + 1 == FRAME_SAMPLES) ? 0 : idx + 1;
        spots = '{idx, nxt, FRAME_SAMPLES + idx, FRAME_SAMPLES + nxt};
        foreach (spots[k]) begin
            if (!filled[spots[k]]) begin
                push_write(spots[k], random_sample());
            end
        end
        push_entry(SEQ_WORD, MODE_READ, $urandom, random_sample(), phase, morph, '0, 0, 0);
        reads_planned++;
    endtask

    task automatic push_random_words(int unsigned count, logic [BASE_W-1:0] base);
        repeat (count) begin
            if ($urandom_range(99) < 30) begin
                push_write($urandom_range(STORE_DEPTH - 1), random_sample());
            end else begin
                push_read(random_phase(), random_morph(base));
            end
        end
    endtask

    always @(posedge i_clk) begin : drive_words
        t_seq_entry head;
        logic       valid_n;
        logic       we_n;
        if (!i_rst_n) begin
            i_valid      <= 1'b0;
            i_cfg_we     <= 1'b0;
            settle_count <= 0;
        end else begin
            valid_n = i_valid;
            we_n    = 1'b0;
            if (i_valid && o_ready) begin
                valid_n = 1'b0;
                if (i_mode == MODE_WRITE) begin
                    shadow_wave[i_write_address] = i_write_data;
                end else begin
                    pending_samples.push_back(morph_lookup_sample(i_phase, i_morph));
                    reads_issued++;
                end
            end
            if (!valid_n && word_queue.size() != 0) begin
                head = word_queue[0];
                case (head.kind)
                    SEQ_PACE: begin
                        send_idle_pct <= head.send_pct;
                        recv_idle_pct <= head.recv_pct;
                        void'(word_queue.pop_front());
                    end
                    SEQ_BASE: begin
                        // hold off until every read has come back and the store is quiet
                        if (reads_issued != samples_seen) begin
                            settle_count <= 0;
                        end else if (settle_count < SETTLE_CYCLES) begin
                            settle_count <= settle_count + 1;
                        end else begin
                            we_n         = 1'b1;
                            i_cfg_wdata  <= head.base;
                            shadow_base  = head.base;
                            settle_count <= 0;
                            void'(word_queue.pop_front());
                        end
                    end
                    default: begin
                        if ($urandom_range(99) >= send_idle_pct) begin
                            valid_n         = 1'b1;
                            i_mode          <= head.mode;
                            i_write_address <= head.addr;
                            i_write_data    <= head.data;
                            i_phase         <= head.phase;
                            i_morph         <= head.morph;
                            void'(word_queue.pop_front());
                        end
                    end
                endcase
            end
            i_valid  <= valid_n;
            i_cfg_we <= we_n;
        end
    end

    always @(posedge i_clk) begin : check_samples
        t_sample want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                samples_seen <= samples_seen + 1;
                if (pending_samples.size() == 0) begin
                    report_mismatch($sformatf("sample %0d with none expected", o_sample));
                end else begin
                    want = pending_samples.pop_front();
                    if (o_sample !== want) begin
                        report_mismatch($sformatf("sample %0d, expected %0d", o_sample, want));
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == WATCHDOG_LIMIT) begin
                $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : run_sequence
        logic [BASE_W-1:0] mid_base;

        // directed part
        push_pace(17, 80);
        push_base(0);
        push_write(0, 32767);
        push_write(1, -32768);
        push_write(FRAME_SAMPLES - 1, -32768);
        push_write(FRAME_SAMPLES, -32768);
        push_write(FRAME_SAMPLES + 1, 32767);
        push_write(STORE_DEPTH - 1, 32767);
        push_read(24'h000000, 16'd0);
        push_read(24'h001fff, 16'hffff);
        push_read(24'hffffff, 16'd4369);
        push_read(24'h001000, 16'd2185);
        push_read(24'h000800, 16'd65529);
        push_read(24'h7ff000, 16'd65530);
        push_write(1, 0);
        push_read(24'h001000, 16'd0);
        push_write(FRAME_SAMPLES + 1, -1);
        push_read(24'h001000, 16'd2185);

        // random part over several base frames and pacing modes
        push_random_words(ITEMS_PER_PHASE, 0);
        push_base(14);
        push_random_words(ITEMS_PER_PHASE, 14);
        push_pace(80, 17);
        push_base(15);
        push_random_words(ITEMS_PER_PHASE, 15);
        push_base(7);
        push_random_words(ITEMS_PER_PHASE, 7);
        push_pace(0, 0);
        mid_base = $urandom_range(FRAME_SPAN - 1);
        push_base(mid_base);
        push_random_words(ITEMS_PER_PHASE, mid_base);
        push_base(1);
        push_random_words(ITEMS_PER_PHASE, 1);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(negedge i_clk);
        end while (word_queue.size() != 0 || i_valid || i_cfg_we ||
                   reads_issued != samples_seen);
        repeat (END_CYCLES) @(negedge i_clk);

        if (pending_samples.size() != 0) begin
            report_mismatch($sformatf("%0d expected samples never arrived",
                                      pending_samples.size()));
        end
        $display("covered %0d store writes and %0d interpolated reads across 6 base frame writes",
                 writes_planned, reads_planned);
        $display("%0d sample mismatches", mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
